// ----- rtl/foc_pkg.sv -----
// Shared types and constants for the FOC current loop.
package foc_pkg;

   localparam int SineTableBitsDefault = 10;

   // Configuration register indexes
   localparam logic [2:0] REG_POLE_PAIRS = 3'd0;
   localparam logic [2:0] REG_THREE_PHASE = 3'd1;
   localparam logic [2:0] REG_GAIN_PROP = 3'd2;
   localparam logic [2:0] REG_GAIN_INTEG = 3'd3;
   localparam logic [2:0] REG_OUT_LIMIT = 3'd4;

   localparam int CsrDataWidth = 16;
   localparam int CsrIndexWidth = 3;

   // 1/sqrt(3) in Q15
   localparam logic signed [15:0] INV_SQRT3 = 16'sd18919;

   typedef struct packed {
      logic [15:0]        rotor_angle;
      logic signed [15:0] phase_a;
      logic signed [15:0] phase_b;
      logic signed [15:0] phase_c;
      logic [2:0]         sector;
      logic signed [15:0] target_d;
      logic signed [15:0] target_q;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] volt_alpha;
      logic signed [15:0] volt_beta;
      logic signed [15:0] meas_d;
      logic signed [15:0] meas_q;
   } rsp_word_type;

   typedef struct packed {
      logic [6:0]  pole_pairs;
      logic        three_phase_sense;
      logic [15:0] gain_prop;
      logic [15:0] gain_integ;
      logic [14:0] out_limit;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture input word, start
      logic [4:0] step;
   } dp_cmd_type;

endpackage

// ----- rtl/foc_ctrl.sv -----
// Sequencer for the FOC current loop: steps the shared multiplier datapath.
module foc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output foc_pkg::dp_cmd_type     cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;
   localparam logic [4:0] LastStep = 5'd24;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign cmd.load = (state_ff == ST_IDLE) && req_valid;
   assign cmd.step = (state_ff == ST_RUN) ? step_ff : 5'd31;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = 5'd0;
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            step_in = step_ff + 5'd1;
            if (step_ff == LastStep) state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end
endmodule

// ----- rtl/foc_dpath.sv -----
// FOC datapath: one shared 20x18 multiplier with accumulator, sequenced by step.
module foc_dpath #(
   parameter int SINE_TABLE_BITS = foc_pkg::SineTableBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  foc_pkg::cfg_type      cfg,
   input  foc_pkg::dp_cmd_type   cmd,
   input  foc_pkg::req_word_type req_word,
   output foc_pkg::rsp_word_type rsp_word
);
   localparam int Drop = 16 - SINE_TABLE_BITS;

   foc_pkg::req_word_type in_ff;
   logic signed [15:0] sn_ff, cs_ff;
   logic signed [18:0] ia_ff, ib_ff, al_ff, be_ff;
   logic signed [15:0] md_ff, mq_ff, vd_ff, vq_ff, va_ff, vb_ff;
   logic signed [16:0] ed_ff, eq_ff, dprev_ff, qprev_ff;
   logic signed [15:0] ddrv_ff, qdrv_ff;
   logic signed [47:0] acc_ff;
   logic [15:0] theta_ff;
   // sine polynomial operands
   logic [14:0] zs_ff, zc_ff;
   logic        sneg_ff, cneg_ff;
   logic [15:0] z2_ff;

   // multiplier operand select
   logic signed [19:0] op_a;
   logic signed [17:0] op_b;
   logic               acc_clr;
   logic signed [47:0] prod, sum;
   logic signed [47:0] rnd15, rnd12;
   logic signed [47:0] lim_s, lim_pos;
   logic [15:0] p_q, p_c;
   logic [15:0] acc_hi, t1, t2;

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) return 16'sh7fff;
      if (v < -48'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // distance into the quarter wave
   function automatic logic [14:0] zval(input logic [15:0] a);
      return a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
   endfunction

   // last polynomial product to Q15 magnitude, clamped, sign by half turn
   function automatic logic signed [15:0] sine_fin(input logic [47:0] a, input logic neg);
      logic [18:0] s2;
      logic [15:0] mag;
      s2 = {a[31:14], 1'b0};
      mag = (s2 > 19'd32767) ? 16'd32767 : s2[15:0];
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   assign acc_hi = acc_ff[29:14];
   assign t1 = 16'd10512 - acc_hi;
   assign t2 = 16'd25736 - acc_hi;

   always_comb begin
      op_a = '0;
      op_b = '0;
      acc_clr = 1'b1;
      case (cmd.step)
         // sine: z*z, 1160*z2, t1*z2, t2*z
         5'd1: begin op_a = {5'd0, zs_ff}; op_b = {3'd0, zs_ff}; end
         5'd2: begin op_a = {4'd0, acc_hi}; op_b = 18'd1160; end
         5'd3: begin op_a = {4'd0, t1}; op_b = {2'd0, z2_ff}; end
         5'd4: begin op_a = {4'd0, t2}; op_b = {3'd0, zs_ff}; end
         // cosine, same sequence
         5'd5: begin op_a = {5'd0, zc_ff}; op_b = {3'd0, zc_ff}; end
         5'd6: begin op_a = {4'd0, acc_hi}; op_b = 18'd1160; end
         5'd7: begin op_a = {4'd0, t1}; op_b = {2'd0, z2_ff}; end
         5'd8: begin op_a = {4'd0, t2}; op_b = {3'd0, zc_ff}; end
         5'd9: begin
            op_a = 20'(al_ff) + (20'(be_ff) <<< 1);
            op_b = 18'(foc_pkg::INV_SQRT3);
         end
         5'd10: begin op_a = 20'(al_ff); op_b = 18'(cs_ff); end
         5'd11: begin op_a = 20'(be_ff); op_b = 18'(sn_ff); acc_clr = 1'b0; end
         5'd12: begin op_a = 20'(be_ff); op_b = 18'(cs_ff); end
         5'd13: begin op_a = -20'(al_ff); op_b = 18'(sn_ff); acc_clr = 1'b0; end
         5'd15: begin op_a = 20'(ed_ff) - 20'(dprev_ff); op_b = 18'({2'b0, cfg.gain_prop}); end
         5'd16: begin
            op_a = 20'(ed_ff); op_b = 18'({2'b0, cfg.gain_integ}); acc_clr = 1'b0;
         end
         5'd17: begin op_a = 20'(eq_ff) - 20'(qprev_ff); op_b = 18'({2'b0, cfg.gain_prop}); end
         5'd18: begin
            op_a = 20'(eq_ff); op_b = 18'({2'b0, cfg.gain_integ}); acc_clr = 1'b0;
         end
         5'd20: begin op_a = 20'(vd_ff); op_b = 18'(cs_ff); end
         5'd21: begin op_a = -20'(vq_ff); op_b = 18'(sn_ff); acc_clr = 1'b0; end
         5'd22: begin op_a = 20'(vd_ff); op_b = 18'(sn_ff); end
         5'd23: begin op_a = 20'(vq_ff); op_b = 18'(cs_ff); acc_clr = 1'b0; end
         default: ;
      endcase
   end

   assign prod = 48'(op_a) * 48'(op_b);
   assign sum = (acc_clr ? 48'sd0 : acc_ff) + prod;
   assign rnd15 = (acc_ff + 48'sd16384) >>> 15;
   assign rnd12 = (acc_ff + 48'sd2048) >>> 12;
   assign p_q = (theta_ff >> Drop) << Drop;
   assign p_c = p_q + 16'd16384;
   assign lim_s = 48'(ddrv_ff);
   assign lim_pos = 48'($signed({1'b0, cfg.out_limit}));

   // sequenced datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ddrv_ff <= '0;
         qdrv_ff <= '0;
         dprev_ff <= '0;
         qprev_ff <= '0;
      end else begin
         if (cmd.load) begin
            in_ff <= req_word;
            theta_ff <= 16'(req_word.rotor_angle * {9'd0, cfg.pole_pairs});
         end
         acc_ff <= sum;
         case (cmd.step)
            5'd0: begin
               zs_ff <= zval(p_q);
               zc_ff <= zval(p_c);
               sneg_ff <= p_q[15];
               cneg_ff <= p_c[15];
               ia_ff <= 19'(in_ff.phase_a);
               ib_ff <= 19'(in_ff.phase_b);
               if (cfg.three_phase_sense) begin
                  if (in_ff.sector == 3'd1 || in_ff.sector == 3'd6)
                     ia_ff <= -19'(in_ff.phase_b) - 19'(in_ff.phase_c);
                  else if (in_ff.sector == 3'd2 || in_ff.sector == 3'd3)
                     ib_ff <= -19'(in_ff.phase_a) - 19'(in_ff.phase_c);
               end
            end
            5'd1: begin al_ff <= ia_ff; be_ff <= ib_ff; end
            5'd2: z2_ff <= acc_hi;
            5'd5: sn_ff <= sine_fin(acc_ff, sneg_ff);
            5'd6: z2_ff <= acc_hi;
            5'd9: cs_ff <= sine_fin(acc_ff, cneg_ff);
            // be held ib; Clarke product (ia + 2*ib) * 1/sqrt3 is in acc
            5'd10: be_ff <= 19'(rnd15);
            5'd12: md_ff <= sat16(rnd15);
            5'd14: begin
               mq_ff <= sat16(rnd15);
               ed_ff <= 17'(in_ff.target_d) - 17'(md_ff);
            end
            5'd15: eq_ff <= 17'(in_ff.target_q) - 17'(mq_ff);
            5'd17: begin
               if (lim_s + rnd12 > lim_pos) ddrv_ff <= 16'(cfg.out_limit);
               else if (lim_s + rnd12 < -lim_pos) ddrv_ff <= -16'(cfg.out_limit);
               else ddrv_ff <= 16'(lim_s + rnd12);
               dprev_ff <= ed_ff;
            end
            5'd19: begin
               if (48'(qdrv_ff) + rnd12 > lim_pos)
                  qdrv_ff <= 16'(cfg.out_limit);
               else if (48'(qdrv_ff) + rnd12 < -lim_pos)
                  qdrv_ff <= -16'(cfg.out_limit);
               else qdrv_ff <= 16'(48'(qdrv_ff) + rnd12);
               qprev_ff <= eq_ff;
               vd_ff <= ddrv_ff;
            end
            5'd20: vq_ff <= qdrv_ff;
            5'd22: va_ff <= sat16(rnd15);
            5'd24: vb_ff <= sat16(rnd15);
            default: ;
         endcase
      end
   end

   assign rsp_word.volt_alpha = va_ff;
   assign rsp_word.volt_beta = vb_ff;
   assign rsp_word.meas_d = md_ff;
   assign rsp_word.meas_q = mq_ff;
endmodule

// ----- rtl/foc_current_loop.sv -----
// Top level of the FOC current loop.
// One word at a time runs through a single shared multiplier. After accept the
// sequencer takes 25 steps: sine and cosine polynomials (eight multiplies), Clarke,
// Park, both PI loops and inverse Park, and then holds the result valid until taken.
// The input stalls from accept until the result has been taken, so a new word is
// only taken once the last result has left. Configuration writes land directly;
// write only with no word in flight.
module foc_current_loop #(
   parameter int SINE_TABLE_BITS = foc_pkg::SineTableBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  foc_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output foc_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_write,
   input  logic [foc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [foc_pkg::CsrDataWidth-1:0]    csr_data
);
   foc_pkg::cfg_type    cfg_ff;
   foc_pkg::dp_cmd_type cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pole_pairs <= 7'd7;
         cfg_ff.three_phase_sense <= 1'b0;
         cfg_ff.gain_prop <= 16'd0;
         cfg_ff.gain_integ <= 16'd0;
         cfg_ff.out_limit <= 15'h7fff;
      end else if (csr_write) begin
         unique case (csr_index)
            foc_pkg::REG_POLE_PAIRS: cfg_ff.pole_pairs <= csr_data[6:0];
            foc_pkg::REG_THREE_PHASE: cfg_ff.three_phase_sense <= csr_data[0];
            foc_pkg::REG_GAIN_PROP: cfg_ff.gain_prop <= csr_data;
            foc_pkg::REG_GAIN_INTEG: cfg_ff.gain_integ <= csr_data;
            foc_pkg::REG_OUT_LIMIT: cfg_ff.out_limit <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   foc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd)
   );

   foc_dpath #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dpath (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd(cmd),
      .req_word(req_word), .rsp_word(rsp_word)
   );
endmodule

// ----- dv/tb_foc_current_loop.sv -----
// Self-checking testbench for the FOC current loop block.
module tb_foc_current_loop;

   localparam int SineDrop = 16 - foc_pkg::SineTableBitsDefault;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   foc_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   foc_pkg::rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [foc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [foc_pkg::CsrDataWidth-1:0] csr_data = '0;

   foc_current_loop u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Predictor copy of registers and loop state
   int unsigned pp_cfg, sense_cfg, kp_cfg, ki_cfg, lim_cfg;
   longint d_drive_m, q_drive_m, d_err_m, q_err_m;
   foc_pkg::rsp_word_type volt_queue[$];
   int errors = 0;
   int cycle_count = 0;
   bit hold_off = 0;
   bit rsp_idle_on = 1;
   int rsp_wait = 0;

   function automatic longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint poly_sine(bit [15:0] p);
      longint z, z2, t, s, mag;
      z = p[14] ? 16384 - p[13:0] : p[13:0];
      z2 = (z * z) >> 14;
      t = 10512 - ((1160 * z2) >> 14);
      t = 25736 - ((t * z2) >> 14);
      s = (t * z) >> 14;
      mag = 2 * s;
      if (mag > 32767) mag = 32767;
      return p[15] ? -mag : mag;
   endfunction

   function automatic longint pi_step(ref longint drive, ref longint prev, input longint tgt,
                                      input longint meas);
      longint e, inc;
      e = tgt - meas;
      inc = longint'(kp_cfg) * (e - prev) + longint'(ki_cfg) * e;
      drive = sat(drive + rnd_shift(inc, 12), -longint'(lim_cfg), longint'(lim_cfg));
      prev = e;
      return drive;
   endfunction

   // Expected result for one control period
   function automatic foc_pkg::rsp_word_type predict_volts(foc_pkg::req_word_type w);
      bit [15:0] theta, p;
      longint sn, cs, ia, ib, ic, al, be, md, mq, vd, vq;
      foc_pkg::rsp_word_type r;
      theta = 16'(w.rotor_angle * pp_cfg);
      p = (theta >> SineDrop) << SineDrop;
      sn = poly_sine(p);
      cs = poly_sine(p + 16'd16384);
      ia = w.phase_a; ib = w.phase_b; ic = w.phase_c;
      if (sense_cfg != 0) begin
         case (w.sector)
            3'd1, 3'd6: ia = -ib - ic;
            3'd2, 3'd3: ib = -ia - ic;
            3'd4, 3'd5: ic = -ia - ib;
            default: ;
         endcase
      end
      al = ia;
      be = rnd_shift((ia + 2 * ib) * 18919, 15);
      md = sat(rnd_shift(al * cs + be * sn, 15), -32768, 32767);
      mq = sat(rnd_shift(be * cs - al * sn, 15), -32768, 32767);
      vd = pi_step(d_drive_m, d_err_m, w.target_d, md);
      vq = pi_step(q_drive_m, q_err_m, w.target_q, mq);
      r.volt_alpha = 16'(sat(rnd_shift(vd * cs - vq * sn, 15), -32768, 32767));
      r.volt_beta = 16'(sat(rnd_shift(vd * sn + vq * cs, 15), -32768, 32767));
      r.meas_d = 16'(md);
      r.meas_q = 16'(mq);
      return r;
   endfunction

   // Register write, predictor follows
   task automatic write_reg(logic [foc_pkg::CsrIndexWidth-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= 16'(val);
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         foc_pkg::REG_POLE_PAIRS: pp_cfg = val & 32'h7F;
         foc_pkg::REG_THREE_PHASE: sense_cfg = val & 1;
         foc_pkg::REG_GAIN_PROP: kp_cfg = val & 32'hFFFF;
         foc_pkg::REG_GAIN_INTEG: ki_cfg = val & 32'hFFFF;
         foc_pkg::REG_OUT_LIMIT: lim_cfg = val & 32'h7FFF;
         default: ;
      endcase
   endtask

   // Drop valid and wait until every word has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (volt_queue.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic set_loop(int unsigned pp, int unsigned sense, int unsigned kp,
                           int unsigned ki, int unsigned lim);
      wait_drain();
      write_reg(foc_pkg::REG_POLE_PAIRS, pp);
      write_reg(foc_pkg::REG_THREE_PHASE, sense);
      write_reg(foc_pkg::REG_GAIN_PROP, kp);
      write_reg(foc_pkg::REG_GAIN_INTEG, ki);
      write_reg(foc_pkg::REG_OUT_LIMIT, lim);
   endtask

   // Offer one word, after an optional random gap; valid stays up after accept
   task automatic send_word(foc_pkg::req_word_type w, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(13) : 0;
      if ($urandom_range(3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      volt_queue.push_back(predict_volts(w));
   endtask

   function automatic foc_pkg::req_word_type random_word();
      foc_pkg::req_word_type w;
      w.rotor_angle = 16'($urandom);
      w.phase_a = 16'($urandom);
      w.phase_b = 16'($urandom);
      w.phase_c = 16'($urandom);
      w.sector = 3'($urandom);
      w.target_d = 16'($urandom);
      w.target_q = 16'($urandom);
      if ($urandom_range(3) != 0) begin
         // realistic currents reach the loop without saturation
         w.phase_a = 16'($signed($urandom_range(8000)) - 4000);
         w.phase_b = 16'($signed($urandom_range(8000)) - 4000);
         w.phase_c = 16'($signed(-w.phase_a - w.phase_b));
         w.target_d = 16'($signed($urandom_range(8000)) - 4000);
         w.target_q = 16'($signed($urandom_range(8000)) - 4000);
      end
      return w;
   endfunction

   // Result stall: a wait drawn per word, or a long hold-off
   always @(posedge clock) begin
      int wait_n;
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         // word taken at this edge, draw the wait for the next one
         wait_n = rsp_idle_on ? $urandom_range(13) : 0;
         rsp_wait <= wait_n;
         rsp_stall <= (wait_n != 0);
      end else if (rsp_wait != 0) begin
         if (rsp_valid) begin
            rsp_wait <= rsp_wait - 1;
            rsp_stall <= (rsp_wait > 1);
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker
   always @(posedge clock) begin
      foc_pkg::rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (volt_queue.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_word);
            errors++;
         end else begin
            exp_w = volt_queue.pop_front();
            if (rsp_word.volt_alpha !== exp_w.volt_alpha) begin
               $display("%0t volt_alpha exp %0d got %0d", $time, exp_w.volt_alpha,
                        rsp_word.volt_alpha);
               errors++;
            end
            if (rsp_word.volt_beta !== exp_w.volt_beta) begin
               $display("%0t volt_beta exp %0d got %0d", $time, exp_w.volt_beta,
                        rsp_word.volt_beta);
               errors++;
            end
            if (rsp_word.meas_d !== exp_w.meas_d) begin
               $display("%0t meas_d exp %0d got %0d", $time, exp_w.meas_d, rsp_word.meas_d);
               errors++;
            end
            if (rsp_word.meas_q !== exp_w.meas_q) begin
               $display("%0t meas_q exp %0d got %0d", $time, exp_w.meas_q, rsp_word.meas_q);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Field extremes, every sector, with and without rebuild
   task automatic test_directed();
      foc_pkg::req_word_type w;
      set_loop(1, 0, 4096, 0, 32767);
      w = '{16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 3'd0, 16'sh7FFF, 16'sh8000};
      send_word(w);
      w = '{16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 3'd7, 16'sh8000, 16'sh7FFF};
      send_word(w);
      w = '{16'h4000, 16'sh0000, 16'sh0000, 16'sh0000, 3'd3, 16'sh0000, 16'sh0000};
      send_word(w);
      set_loop(64, 1, 65535, 65535, 32767);
      for (int s = 0; s < 8; s++) begin
         w = '{16'(s * 9000), 16'sh7FFF, 16'sh7FFF, 16'sh8000, 3'(s), 16'sh1234, 16'shEDCB};
         send_word(w);
      end
      w = '{16'h2000, 16'sh8000, 16'sh8000, 16'sh8000, 3'd4, 16'sh8000, 16'sh8000};
      send_word(w);
      // pole pairs zero and zero limit
      set_loop(0, 1, 300, 200, 0);
      for (int i = 0; i < 4; i++) send_word(random_word());
      set_loop(5, 0, 0, 0, 1);
      for (int i = 0; i < 4; i++) send_word(random_word());
   endtask

   // Random words under several loop settings
   task automatic test_random();
      for (int ph = 0; ph < 8; ph++) begin
         set_loop($urandom_range(ph == 0 ? 1 : 64), $urandom_range(1),
                  ph == 1 ? 65535 : $urandom_range(8000),
                  ph == 2 ? 65535 : $urandom_range(2000),
                  ph == 3 ? 32767 : $urandom_range(32767));
         rsp_idle_on = (ph != 4);
         for (int i = 0; i < 100; i++) send_word(random_word(), ph != 4);
      end
      rsp_idle_on = 1;
   endtask

   // Receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      wait_drain();
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 20; i++) send_word(random_word(), 0);
            wait_drain();
         end
      join
   endtask

   initial begin
      pp_cfg = 7; sense_cfg = 0; kp_cfg = 0; ki_cfg = 0; lim_cfg = 32767;
      d_drive_m = 0; q_drive_m = 0; d_err_m = 0; q_err_m = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      wait_drain();
      if (errors == 0 && volt_queue.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/foc_pkg.sv
rtl/foc_ctrl.sv
rtl/foc_dpath.sv
rtl/foc_current_loop.sv
dv/tb_foc_current_loop.sv
